// ----- sv/sit_pkg.sv -----
// Shared types and constants for the sorted insertion table.
package sit_pkg;

	localparam int CAPACITY_DEFAULT = 16;
	localparam int TAG_W = 16;
	localparam int TIME_W = 20;
	localparam int COUNT_OUT_W = 5;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [TIME_W-1:0] time_key;
	} entry_t;

endpackage

// ----- sv/sit_cell.sv -----
// One storage cell of the sorted insertion chain.
module sit_cell (
	input  logic            clk,
	input  logic            load,
	input  logic            occ,
	input  sit_pkg::entry_t new_entry,
	input  sit_pkg::entry_t prev_entry,
	input  logic            prev_move,
	output sit_pkg::entry_t entry,
	output logic            move,
	output sit_pkg::entry_t entry_next
);

	sit_pkg::entry_t entry_q;

	// This cell is at or past the insertion point when it is empty or holds a later time.
	assign move = !occ || (entry_q.time_key > new_entry.time_key);

	always_comb begin
		if (prev_move) begin
			entry_next = prev_entry;
		end else if (move) begin
			entry_next = new_entry;
		end else begin
			entry_next = entry_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= entry_next;
		end
	end

	assign entry = entry_q;

endmodule

// ----- sv/sorted_insertion_table.sv -----
// Top level of the sorted insertion table: a chain of cells kept in ascending time order.
//
// Each transaction presents entry_tag and time_key with start high; it is taken at any
// rising edge where start is high and busy is low, and busy never rises, so one
// transaction can be taken every cycle. In the cycle after it is taken, done pulses for one
// cycle with the front and back entries, the count after the insertion, and the drop
// flag. The receiver cannot stall, so results must be captured on the done cycle.
// The insertion itself happens at the edge that takes it: every cell compares its stored time with the
// new key in parallel and either keeps its entry, takes the new one, or takes its
// left neighbor's, so the chain shifts one place behind the insertion point.
// A new entry goes ahead of the first stored entry with a strictly greater time, so
// equal times keep their arrival order. When the table is full, the entry that would
// end up last is discarded (possibly the new one) and dropped is raised.
// The cells need no clearing after reset; only cells below the count are ever used.
module sorted_insertion_table #(
	parameter int CAPACITY = sit_pkg::CAPACITY_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [sit_pkg::TAG_W-1:0]       entry_tag,
	input  logic [sit_pkg::TIME_W-1:0]      time_key,
	output logic                            done,
	output logic [sit_pkg::TAG_W-1:0]       first_tag,
	output logic [sit_pkg::TIME_W-1:0]      first_time,
	output logic [sit_pkg::TAG_W-1:0]       last_tag,
	output logic [sit_pkg::TIME_W-1:0]      last_time,
	output logic [sit_pkg::COUNT_OUT_W-1:0] entry_count,
	output logic                            dropped
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic            load;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   count_next;
	logic            full;
	logic            appended;
	sit_pkg::entry_t new_entry;
	sit_pkg::entry_t last_q;
	sit_pkg::entry_t last_next;
	sit_pkg::entry_t first_q;
	sit_pkg::entry_t cell_entry [CAPACITY];
	sit_pkg::entry_t cell_next  [CAPACITY];
	logic            cell_move  [CAPACITY];
	logic [sit_pkg::COUNT_OUT_W-1:0] count_out_q;
	logic            dropped_q;
	logic            done_q;

	// Every transaction finishes in the cycle it is taken, so the block never holds off.
	assign busy = 1'b0;
	assign load = start && !busy;
	assign new_entry.tag = entry_tag;
	assign new_entry.time_key = time_key;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			sit_pkg::entry_t prev_entry;
			logic            prev_move;
			logic            occ;

			assign occ = (CW'(gi) < count_q);

			if (gi == 0) begin : g_head
				assign prev_entry = new_entry;
				assign prev_move = 1'b0;
			end else begin : g_body
				assign prev_entry = cell_entry[gi-1];
				assign prev_move = cell_move[gi-1];
			end

			sit_cell u_cell (
				.clk        (clk),
				.load       (load),
				.occ        (occ),
				.new_entry  (new_entry),
				.prev_entry (prev_entry),
				.prev_move  (prev_move),
				.entry      (cell_entry[gi]),
				.move       (cell_move[gi]),
				.entry_next (cell_next[gi])
			);
		end
	endgenerate

	assign full = (count_q == CW'(CAPACITY));

	// The table is sorted, so the new entry lands at the end exactly when the current
	// last entry is not later than it.
	assign appended = (count_q == '0) || !(last_q.time_key > time_key);

	always_comb begin
		if (full) begin
			last_next = cell_next[CAPACITY-1];
		end else if (appended) begin
			last_next = new_entry;
		end else begin
			last_next = last_q;
		end
	end

	assign count_next = full ? count_q : count_q + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= load;
			if (load) begin
				count_q <= count_next;
			end
		end
	end

	// Result payload registers carry no reset; they are qualified by done.
	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= last_next;
			first_q <= cell_next[0];
			count_out_q <= sit_pkg::COUNT_OUT_W'(count_next);
			dropped_q <= full;
		end
	end

	assign done = done_q;
	assign first_tag = first_q.tag;
	assign first_time = first_q.time_key;
	assign last_tag = last_q.tag;
	assign last_time = last_q.time_key;
	assign entry_count = count_out_q;
	assign dropped = dropped_q;

endmodule

// ----- sv/sit_checker.sv -----
// Port-level checker for the sorted insertion table, bound to the top level.
module sit_checker #(
	parameter int CAPACITY = sit_pkg::CAPACITY_DEFAULT
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic [sit_pkg::TAG_W-1:0]       entry_tag,
	input logic [sit_pkg::TIME_W-1:0]      time_key,
	input logic                            done,
	input logic [sit_pkg::TAG_W-1:0]       first_tag,
	input logic [sit_pkg::TIME_W-1:0]      first_time,
	input logic [sit_pkg::TAG_W-1:0]       last_tag,
	input logic [sit_pkg::TIME_W-1:0]      last_time,
	input logic [sit_pkg::COUNT_OUT_W-1:0] entry_count,
	input logic                            dropped
);

	// Each taken transaction yields exactly one result on the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("result missing after a taken transaction");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without a taken transaction");

	// The table stays ordered, so the front never comes after the back.
	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (first_time <= last_time))
		else $error("front entry later than back entry");

	// A drop happens only when the table already held its full capacity.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dropped) |-> (entry_count == sit_pkg::COUNT_OUT_W'(CAPACITY)))
		else $error("entry dropped below capacity");

	// Back-to-back results without a drop grow the count by one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && !dropped) |->
		(entry_count == $past(entry_count) + sit_pkg::COUNT_OUT_W'(1)))
		else $error("count did not advance by one");

endmodule

bind sorted_insertion_table sit_checker #(.CAPACITY(CAPACITY)) u_sit_checker (.*);

// ----- test/tb_top.sv -----
// Testbench for the sorted insertion table: a queue-fed driver, a result monitor and a predictor.
`timescale 1ns / 100ps

module tb_top;

	localparam int TAG_W = sit_pkg::TAG_W;
	localparam int TIME_W = sit_pkg::TIME_W;
	localparam int COUNT_OUT_W = sit_pkg::COUNT_OUT_W;
	localparam int CAPACITY = sit_pkg::CAPACITY_DEFAULT;
	localparam int RANDOM_ITEMS = 1600;
	localparam int LIMIT_CYCLES = 400000;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// One queued transaction: the entry, the idle cycles that precede it, and whether
	// the driver must first wait for every outstanding result (a drain point).
	typedef struct {
		logic [TAG_W-1:0]  tag;
		logic [TIME_W-1:0] tkey;
		int                gap;
		bit                hold;
	} entry_item_t;

	// The summary that the table reports after one insertion.
	typedef struct packed {
		logic [TAG_W-1:0]       first_tag;
		logic [TIME_W-1:0]      first_time;
		logic [TAG_W-1:0]       last_tag;
		logic [TIME_W-1:0]      last_time;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic                   dropped;
	} table_summary_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [TAG_W-1:0] entry_tag = '0;
	logic [TIME_W-1:0] time_key = '0;

	logic busy;
	logic done;
	logic [TAG_W-1:0] first_tag;
	logic [TIME_W-1:0] first_time;
	logic [TAG_W-1:0] last_tag;
	logic [TIME_W-1:0] last_time;
	logic [COUNT_OUT_W-1:0] entry_count;
	logic dropped;

	// Transactions still to be offered, and summaries predicted but not yet seen.
	entry_item_t entry_backlog[$];
	table_summary_t predicted_summaries[$];

	// The predictor's own copy of the table.
	logic [TAG_W-1:0] sorted_tags[CAPACITY];
	logic [TIME_W-1:0] sorted_times[CAPACITY];
	int held_entries = 0;

	int mismatch_count = 0;
	int idle_run = 0;
	int cycle_count = 0;

	sorted_insertion_table #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.entry_tag(entry_tag),
		.time_key(time_key),
		.done(done),
		.first_tag(first_tag),
		.first_time(first_time),
		.last_tag(last_tag),
		.last_time(last_time),
		.entry_count(entry_count),
		.dropped(dropped)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns ERROR: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
		end
	endtask

	// Insert one entry into the predicted table and queue the summary it causes.
	// The entry goes ahead of the first stored time that is strictly greater, so
	// equal times keep their arrival order. When the table is already full, the
	// entry that would end up last is discarded: the new one if it belongs at the
	// end, otherwise the current last entry.
	task automatic predict_insertion(input logic [TAG_W-1:0] tag, input logic [TIME_W-1:0] tkey);
		int pos;
		int k;
		table_summary_t sum;
		pos = held_entries;
		for (k = 0; k < held_entries; k++) begin
			if (pos == held_entries && sorted_times[k] > tkey) begin
				pos = k;
			end
		end
		sum.dropped = 1'b0;
		if (held_entries >= CAPACITY) begin
			sum.dropped = 1'b1;
			if (pos < CAPACITY) begin
				for (k = CAPACITY - 1; k > pos; k--) begin
					sorted_tags[k] = sorted_tags[k-1];
					sorted_times[k] = sorted_times[k-1];
				end
				sorted_tags[pos] = tag;
				sorted_times[pos] = tkey;
			end
		end else begin
			for (k = held_entries; k > pos; k--) begin
				sorted_tags[k] = sorted_tags[k-1];
				sorted_times[k] = sorted_times[k-1];
			end
			sorted_tags[pos] = tag;
			sorted_times[pos] = tkey;
			held_entries++;
		end
		sum.first_tag = sorted_tags[0];
		sum.first_time = sorted_times[0];
		sum.last_tag = sorted_tags[held_entries-1];
		sum.last_time = sorted_times[held_entries-1];
		sum.entry_count = held_entries[COUNT_OUT_W-1:0];
		predicted_summaries.push_back(sum);
	endtask

	// Idle cycles before a transaction: mostly none or a few, now and then a long pause.
	function automatic int pick_gap(input bit burst);
		int r;
		r = $urandom_range(99);
		if (burst || r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(40, 8);
	endfunction

	// Time keys for the random part. The table never shrinks, so once it is full a key
	// only gets in if it is smaller than the stored maximum. Most keys therefore come
	// from a window that slides down from the top of the range as the run goes on, which
	// keeps insertions at the front, inside and at the back all happening. The rest are
	// full-range keys, repeats of the previous key (ties), the maximum key, and very
	// rarely a tiny key.
	function automatic logic [TIME_W-1:0] pick_key(input int n, input logic [TIME_W-1:0] prev);
		int base;
		int r;
		logic [TIME_W-1:0] k;
		base = int'(TIME_MAX) - n * 640;
		r = $urandom_range(199);
		if (r < 110) begin
			k = TIME_W'(base - int'($urandom_range(2047)));
			k[1:0] = 2'b00;
		end else if (r < 150) begin
			k = TIME_W'($urandom_range(int'(TIME_MAX)));
		end else if (r < 174) begin
			k = prev;
		end else if (r < 199) begin
			k = TIME_MAX;
		end else begin
			k = TIME_W'($urandom_range(15));
		end
		return k;
	endfunction

	function automatic entry_item_t make_item(input logic [TAG_W-1:0] tag,
			input logic [TIME_W-1:0] tkey, input int gap, input bit hold);
		entry_item_t item;
		item.tag = tag;
		item.tkey = tkey;
		item.gap = gap;
		item.hold = hold;
		return item;
	endfunction

	// Driver. A transaction is taken at an edge where start is high and busy is low;
	// the prediction is made right then. After that, or while idle, the next queued
	// transaction is put on the ports once its gap has elapsed and, at a drain point,
	// once every predicted summary has been seen. Start is assigned at most once per edge so
	// that a back-to-back stream never drops it.
	always @(posedge clk) begin
		logic drive_next;
		logic keep_start;
		entry_item_t head;
		keep_start = start;
		drive_next = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				predict_insertion(entry_tag, time_key);
				keep_start = 1'b0;
				idle_run = 0;
			end
			if (!keep_start) begin
				if (entry_backlog.size() != 0) begin
					head = entry_backlog[0];
					if (idle_run >= head.gap && !(head.hold && predicted_summaries.size() != 0)) begin
						drive_next = 1'b1;
						void'(entry_backlog.pop_front());
						entry_tag <= head.tag;
						time_key <= head.tkey;
					end else begin
						idle_run++;
					end
				end
				start <= drive_next;
			end
		end
	end

	// Monitor. Results cannot be held off: each one is on the ports for the single
	// cycle that done marks. Outputs change only at the rising edge, so sampling at the
	// falling edge sees the same values the receiver takes at the end of the cycle.
	always @(negedge clk) begin
		table_summary_t want;
		if (arst_n && done) begin
			if (predicted_summaries.size() == 0) begin
				report_mismatch("result with no transaction outstanding");
			end else begin
				want = predicted_summaries.pop_front();
				check_field("first_tag", 32'(first_tag), 32'(want.first_tag));
				check_field("first_time", 32'(first_time), 32'(want.first_time));
				check_field("last_tag", 32'(last_tag), 32'(want.last_tag));
				check_field("last_time", 32'(last_time), 32'(want.last_time));
				check_field("entry_count", 32'(entry_count), 32'(want.entry_count));
				check_field("dropped", 32'(dropped), 32'(want.dropped));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int n;
		int k;
		bit burst;
		logic [TIME_W-1:0] prev_key;

		// The predicted table starts empty, with its stored entries zeroed.
		for (k = 0; k < CAPACITY; k++) begin
			sorted_tags[k] = '0;
			sorted_times[k] = '0;
		end

		// Directed part. The first entries test the extremes and tie ordering: a maximum
		// key into an empty table, a zero key to the front, an equal zero key behind it,
		// an equal maximum key appended behind the first one, then a key in the middle.
		entry_backlog.push_back(make_item(16'h0000, TIME_MAX, 0, 1'b0));
		entry_backlog.push_back(make_item(16'hFFFF, 20'h00000, 0, 1'b0));
		entry_backlog.push_back(make_item(16'hAAAA, 20'h00000, 1, 1'b0));
		entry_backlog.push_back(make_item(16'h5555, TIME_MAX, 0, 1'b0));
		entry_backlog.push_back(make_item(16'h1234, 20'h80000, 0, 1'b0));
		// Fill the table to capacity.
		for (k = 0; k < CAPACITY - 5; k++) begin
			entry_backlog.push_back(make_item(TAG_W'(16'h0100 + k),
				TIME_W'(20'h40000 + k * 20'h01000), k % 3, 1'b0));
		end
		// Full table. An entry tied with the back belongs last and is itself discarded;
		// the driver drains first so this lands on an idle block.
		entry_backlog.push_back(make_item(16'hBEEF, TIME_MAX, 0, 1'b1));
		// An entry inside pushes the current back entry out.
		entry_backlog.push_back(make_item(16'hCAFE, 20'h7FFFF, 0, 1'b0));
		entry_backlog.push_back(make_item(16'hF00D, 20'h00000, 0, 1'b0));
		entry_backlog.push_back(make_item(16'h0F0F, 20'hFFFFE, 2, 1'b0));
		entry_backlog.push_back(make_item(16'hF0F0, 20'h00001, 0, 1'b0));
		entry_backlog.push_back(make_item(16'h8001, 20'h00000, 0, 1'b0));

		// Random part. Every 64 transactions the run may switch to a burst with no gaps,
		// and every 400 the driver drains before going on.
		prev_key = '0;
		burst = 1'b0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0) begin
				burst = ($urandom_range(3) == 0);
			end
			prev_key = pick_key(n, prev_key);
			entry_backlog.push_back(make_item(TAG_W'($urandom_range(16'hFFFF)), prev_key,
				pick_gap(burst), (n % 400 == 399)));
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every transaction is taken and every result has come back, then
		// let the clock run on so that any stray result from the registered done would still be seen.
		@(negedge clk);
		while (entry_backlog.size() != 0 || start || predicted_summaries.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(posedge clk);
		@(negedge clk);

		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/sit_pkg.sv
sv/sit_cell.sv
sv/sorted_insertion_table.sv
sv/sit_checker.sv
test/tb_top.sv
